FILE: rtl/core/cpg_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the collision pair grouper.
// Used by cpg_ctrl, cpg_datapath and collision_pair_grouper; no dependencies.
package cpg_pkg;

   // Fixed field widths of the request and response items
   localparam int PLAYER_W = 4;
   localparam int SLOT_W   = 3;
   localparam int COUNT_W  = 4;

   // Default sizing, handed to the top level parameters
   localparam int DEF_MAX_PLAYERS = 16;
   localparam int DEF_MAX_GROUPS  = 8;

   // Request codes
   localparam logic REQ_PAIR      = 1'b0;
   localparam logic REQ_FRAME_END = 1'b1;

   typedef struct packed {
      logic                req_type;
      logic [PLAYER_W-1:0] player_a;
      logic [PLAYER_W-1:0] player_b;
   } cpg_req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  group_slot;
      logic               merged;
      logic               new_group;
      logic [COUNT_W-1:0] group_count;
   } cpg_rsp_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } cpg_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;     // capture the accepted request
      logic lookup;   // read memberships and find a free slot
      logic update;   // write back state and issue the response
   } cpg_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic out_free; // response register can take a new item this cycle
   } cpg_status_type;

endpackage

FILE: rtl/core/cpg_ctrl.sv
`timescale 1ns / 1ps
// Controller of the collision pair grouper: sequences load, lookup and update.
// Depends on cpg_pkg.
module cpg_ctrl
   import cpg_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  cpg_status_type status,
   output cpg_cmd_type    cmd
);

   cpg_state_type state_ff;
   cpg_state_type state_in;

   // Hold the state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            // Write back once the response register frees up; take the next
            // request in the same cycle
            if (status.out_free) begin
               cmd.update = 1'b1;
               req_stall  = 1'b0;
               if (req_valid) begin
                  cmd.load = 1'b1;
                  state_in = ST_LOOKUP;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/core/cpg_datapath.sv
`timescale 1ns / 1ps
// Datapath of the collision pair grouper: membership register file, slot
// occupancy, group counter, lookup stage and response register. Depends on cpg_pkg.
module cpg_datapath
   import cpg_pkg::*;
#(
   parameter int MAX_PLAYERS = DEF_MAX_PLAYERS,
   parameter int MAX_GROUPS  = DEF_MAX_GROUPS
) (
   input  logic           clock,
   input  logic           reset,
   input  cpg_req_type    req_data,
   input  cpg_cmd_type    cmd,
   output cpg_status_type status,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output cpg_rsp_type    rsp_data
);

   localparam int IW = (MAX_PLAYERS > 1) ? $clog2(MAX_PLAYERS) : 1;
   localparam int GW = $clog2(MAX_GROUPS + 1);
   localparam int SW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam logic [GW-1:0] NoGroup = GW'(MAX_GROUPS);

   // Architectural state
   logic [GW-1:0] member_ff [MAX_PLAYERS];
   logic [GW-1:0] member_in [MAX_PLAYERS];
   logic [MAX_GROUPS-1:0] use_ff;
   logic [MAX_GROUPS-1:0] use_in;
   logic [GW-1:0] cnt_ff;
   logic [GW-1:0] cnt_in;

   // Request register
   cpg_req_type   in_ff;
   cpg_req_type   in_in;

   // Lookup stage
   logic [GW-1:0] ga_ff, ga_in;
   logic [GW-1:0] gb_ff, gb_in;
   logic          bad_ff, bad_in;
   logic          free_ff, free_in;
   logic [SW-1:0] free_slot_ff, free_slot_in;

   // Response register
   logic          rsp_valid_ff, rsp_valid_in;
   cpg_rsp_type   rsp_data_ff, rsp_data_in;

   logic [IW-1:0] a_idx;
   logic [IW-1:0] b_idx;
   logic          has_a;
   logic          has_b;
   logic          frame_end;
   logic [GW-1:0] join_g;

   assign a_idx     = IW'(in_ff.player_a);
   assign b_idx     = IW'(in_ff.player_b);
   assign has_a     = (ga_ff != NoGroup);
   assign has_b     = (gb_ff != NoGroup);
   assign frame_end = (in_ff.req_type == REQ_FRAME_END);
   assign join_g    = has_a ? ga_ff : gb_ff;

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

   // Capture the request on transfer
   assign in_in = cmd.load ? req_data : in_ff;

   // Lookup: range check, both memberships, lowest free slot
   always_comb begin
      bad_in = (32'(in_ff.player_a) >= 32'(MAX_PLAYERS)) ||
               (32'(in_ff.player_b) >= 32'(MAX_PLAYERS));
      ga_in  = bad_in ? NoGroup : member_ff[a_idx];
      gb_in  = bad_in ? NoGroup : member_ff[b_idx];
      free_in      = 1'b0;
      free_slot_in = '0;
      for (int i = MAX_GROUPS - 1; i >= 0; i--) begin
         if (!use_ff[i]) begin
            free_in      = 1'b1;
            free_slot_in = SW'(i);
         end
      end
   end

   // Update: relabel, join, open or clear, and form the response
   always_comb begin
      for (int i = 0; i < MAX_PLAYERS; i++) begin
         member_in[i] = member_ff[i];
      end
      use_in       = use_ff;
      cnt_in       = cnt_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.update) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         if (frame_end) begin
            rsp_data_in.group_count = COUNT_W'(cnt_ff);
            for (int i = 0; i < MAX_PLAYERS; i++) begin
               member_in[i] = NoGroup;
            end
            use_in = '0;
            cnt_in = '0;
         end else if (bad_ff) begin
            rsp_data_in = '0;
         end else if (has_a && has_b) begin
            rsp_data_in.group_slot = SLOT_W'(ga_ff);
            if (ga_ff != gb_ff) begin
               // Merge the second group into the first and free its slot
               for (int i = 0; i < MAX_PLAYERS; i++) begin
                  if (member_ff[i] == gb_ff) begin
                     member_in[i] = ga_ff;
                  end
               end
               use_in[gb_ff[SW-1:0]] = 1'b0;
               cnt_in                = cnt_ff - GW'(1);
               rsp_data_in.merged    = 1'b1;
            end
         end else if (has_a || has_b) begin
            // The ungrouped player joins the other's group
            member_in[a_idx]       = join_g;
            member_in[b_idx]       = join_g;
            rsp_data_in.group_slot = SLOT_W'(join_g);
         end else if (free_ff) begin
            // Open a fresh group in the lowest free slot
            member_in[a_idx]       = GW'(free_slot_ff);
            member_in[b_idx]       = GW'(free_slot_ff);
            use_in[free_slot_ff]   = 1'b1;
            cnt_in                 = cnt_ff + GW'(1);
            rsp_data_in.group_slot = SLOT_W'(free_slot_ff);
            rsp_data_in.new_group  = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_PLAYERS; i++) begin
            member_ff[i] <= NoGroup;
         end
         use_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < MAX_PLAYERS; i++) begin
            member_ff[i] <= member_in[i];
         end
         use_ff       <= use_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_ff       <= in_in;
      rsp_data_ff <= rsp_data_in;
      if (cmd.lookup) begin
         ga_ff        <= ga_in;
         gb_ff        <= gb_in;
         bad_ff       <= bad_in;
         free_ff      <= free_in;
         free_slot_ff <= free_slot_in;
      end
   end

   // Write back never overruns a response still waiting
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> (!rsp_valid_ff || !rsp_stall))
      else $error("update while response register busy");

   // Group counter tracks occupied slots
   a_count_match: assert property (@(posedge clock) disable iff (reset)
      $countones(use_ff) == int'(cnt_ff))
      else $error("group counter out of step with slot occupancy");

   // Frame end leaves every slot free
   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && frame_end) |=> (use_ff == '0 && cnt_ff == '0))
      else $error("slots not cleared at frame end");

   // A lookup is always followed by an update before another lookup
   a_lookup_then_update: assert property (@(posedge clock) disable iff (reset)
      cmd.lookup |=> !cmd.lookup)
      else $error("back to back lookups");

endmodule

FILE: rtl/core/collision_pair_grouper.sv
`timescale 1ns / 1ps
// Top level of the collision pair grouper: controller plus datapath.
// Depends on cpg_pkg, cpg_ctrl and cpg_datapath.
//
// Groups the colliding player pairs of one frame into clusters. A pair
// request either opens a group in the lowest free slot, adds the ungrouped
// player to the other's group, merges the second player's group into the
// first, or leaves the groups unchanged. A frame-end request returns the
// number of non-empty groups and clears all memberships. Each request
// passes a lookup step that reads both memberships and finds a free slot,
// then an update step that writes the membership register file back (a
// merge relabels all entries in parallel) and loads the response register.
// The next request is taken in the update step of the current one; a
// stalled response holds off the write back of the following request. No
// clearing pass is needed after reset.
module collision_pair_grouper
   import cpg_pkg::*;
#(
   parameter int MAX_PLAYERS = DEF_MAX_PLAYERS,
   parameter int MAX_GROUPS  = DEF_MAX_GROUPS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  cpg_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output cpg_rsp_type rsp_data
);

   cpg_cmd_type    cmd;
   cpg_status_type status;

   cpg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cpg_datapath #(
      .MAX_PLAYERS (MAX_PLAYERS),
      .MAX_GROUPS  (MAX_GROUPS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for collision_pair_grouper: directed and random pair and
// frame-end requests, each response checked against an in-bench grouping predictor.
// Depends on cpg_pkg and the collision_pair_grouper RTL.
module tb;
   import cpg_pkg::*;

   localparam int NUM_PLAYERS  = DEF_MAX_PLAYERS;
   localparam int NUM_SLOTS    = DEF_MAX_GROUPS;
   localparam int MEMB_W       = $clog2(NUM_SLOTS + 1);
   localparam int SLOT_IW      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam logic [MEMB_W-1:0] UNGROUPED = MEMB_W'(NUM_SLOTS);
   localparam int LONG_HOLD    = 300;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_REPORTS  = 10;

   typedef enum logic {SEND_STEADY, SEND_BURSTY} send_mode_type;
   typedef enum logic [1:0] {RCV_OPEN, RCV_RANDOM, RCV_PATTERN} rcv_mode_type;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   cpg_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   cpg_rsp_type rsp_data;

   // Predictor state: slot of each player and occupancy of each slot
   logic [MEMB_W-1:0]    player_slot [NUM_PLAYERS];
   logic [NUM_SLOTS-1:0] slot_busy;
   cpg_rsp_type          expected_rsp_q [$];

   send_mode_type send_mode   = SEND_STEADY;
   rcv_mode_type  rcv_mode    = RCV_OPEN;
   int         burst_left  = 0;
   int         hold_ask    = 0;
   int         hold_seen   = 0;
   int         hold_left   = 0;
   int         rcv_tick    = 0;
   int         quiet_cycles = 0;

   int reqs_sent     = 0;
   int rsps_checked  = 0;
   int mismatches    = 0;
   int frames_closed = 0;
   int merges_seen   = 0;
   int groups_opened = 0;
   int full_refusals = 0;

   collision_pair_grouper uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   // Drop every membership and free every slot
   function automatic void clear_groups();
      for (int i = 0; i < NUM_PLAYERS; i++) player_slot[i] = UNGROUPED;
      slot_busy = '0;
   endfunction

   // Apply one request to the predictor state and return the response it should give
   function automatic cpg_rsp_type predict_grouping(input cpg_req_type r);
      cpg_rsp_type rsp;
      logic [MEMB_W-1:0] sa;
      logic [MEMB_W-1:0] sb;
      int free_slot;
      rsp = '0;
      if (r.req_type == REQ_FRAME_END) begin
         rsp.group_count = COUNT_W'($countones(slot_busy));
         clear_groups();
         frames_closed++;
         return rsp;
      end
      sa = player_slot[r.player_a];
      sb = player_slot[r.player_b];
      if (sa != UNGROUPED && sb != UNGROUPED) begin
         // both grouped: relabel b's group into a's unless already shared
         rsp.group_slot = SLOT_W'(sa);
         if (sa != sb) begin
            for (int i = 0; i < NUM_PLAYERS; i++)
               if (player_slot[i] == sb) player_slot[i] = sa;
            slot_busy[sb[SLOT_IW-1:0]] = 1'b0;
            rsp.merged = 1'b1;
            merges_seen++;
         end
      end else if (sa != UNGROUPED || sb != UNGROUPED) begin
         // one grouped: the other joins it
         if (sa == UNGROUPED) sa = sb;
         player_slot[r.player_a] = sa;
         player_slot[r.player_b] = sa;
         rsp.group_slot = SLOT_W'(sa);
      end else begin
         // neither grouped: open the lowest free slot, or refuse when none is left
         free_slot = -1;
         for (int i = NUM_SLOTS - 1; i >= 0; i--)
            if (!slot_busy[i]) free_slot = i;
         if (free_slot < 0) begin
            full_refusals++;
         end else begin
            slot_busy[free_slot] = 1'b1;
            player_slot[r.player_a] = MEMB_W'(free_slot);
            player_slot[r.player_b] = MEMB_W'(free_slot);
            rsp.group_slot = SLOT_W'(free_slot);
            rsp.new_group = 1'b1;
            groups_opened++;
         end
      end
      return rsp;
   endfunction

   function automatic cpg_req_type pair_req(input int a, input int b);
      cpg_req_type r;
      r.req_type = REQ_PAIR;
      r.player_a = PLAYER_W'(a);
      r.player_b = PLAYER_W'(b);
      return r;
   endfunction

   function automatic cpg_req_type frame_end_req(input int a, input int b);
      cpg_req_type r;
      r.req_type = REQ_FRAME_END;
      r.player_a = PLAYER_W'(a);
      r.player_b = PLAYER_W'(b);
      return r;
   endfunction

   function automatic void report_mismatch(input string what, input cpg_rsp_type want,
                                           input cpg_rsp_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display({"%0t: %s: expected slot %0d merged %0b new %0b count %0d,",
                   " got slot %0d merged %0b new %0b count %0d"},
                  $realtime, what, want.group_slot, want.merged, want.new_group,
                  want.group_count, got.group_slot, got.merged, got.new_group,
                  got.group_count);
   endfunction

   // Offer one request, hold it until the transfer, record its expected response
   task automatic send_req(input cpg_req_type item);
      int gap;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      expected_rsp_q.push_back(predict_grouping(item));
      reqs_sent++;
      if (send_mode == SEND_BURSTY) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(0, 12);
            gap = $urandom_range(1, 6);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            burst_left--;
         end
      end
   endtask

   // Stop offering, wait for every outstanding response, then let the pipeline settle
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Check each response transfer, then pick the stall for the next cycle
   always @(posedge clock) begin : rsp_checker
      cpg_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         rsps_checked++;
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("response with none outstanding", '0, rsp_data);
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_data.group_slot !== want.group_slot || rsp_data.merged !== want.merged
                || rsp_data.new_group !== want.new_group
                || rsp_data.group_count !== want.group_count)
               report_mismatch("response mismatch", want, rsp_data);
         end
      end
      rcv_tick <= rcv_tick + 1;
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_ask != hold_seen) begin
         hold_seen <= hold_ask;
         hold_left <= LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else begin
         case (rcv_mode)
            RCV_OPEN:    rsp_stall <= 1'b0;
            RCV_RANDOM:  rsp_stall <= ($urandom_range(0, 99) < 35);
            default:     rsp_stall <= ((rcv_tick % 7) < 3);
         endcase
      end
   end

   // End the run when no transfer happens for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == IDLE_LIMIT) begin
         $display("collision_pair_grouper verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Open, join, shared-group, single-player, merge and slot reuse
   task automatic test_pair_cases();
      send_mode = SEND_STEADY;
      rcv_mode <= RCV_OPEN;
      send_req(frame_end_req(15, 15));   // empty frame, player fields ignored
      send_req(pair_req(0, 15));         // open slot 0
      send_req(pair_req(15, 3));         // first grouped, second joins
      send_req(pair_req(5, 0));          // second grouped, first joins
      send_req(pair_req(0, 15));         // already in the same group
      send_req(pair_req(7, 7));          // same player, opens a single-player group
      send_req(pair_req(7, 7));          // same player, already grouped
      send_req(pair_req(7, 0));          // merge slot 0 into slot 1
      send_req(pair_req(9, 10));         // freed slot 0 is reused
      send_req(frame_end_req(0, 0));
   endtask

   // Fill every slot, refuse a new group, free one by a merge, fill it again
   task automatic test_slot_exhaustion();
      send_mode = SEND_BURSTY;
      rcv_mode <= RCV_RANDOM;
      for (int p = 0; p < NUM_SLOTS; p++) send_req(pair_req(p, p));
      send_req(pair_req(8, 9));
      send_req(pair_req(0, 1));
      send_req(pair_req(8, 9));
      send_req(pair_req(15, 15));
      send_req(frame_end_req(10, 5));
   endtask

   // Hold the response side for a long stretch while requests keep coming
   task automatic test_backpressure();
      send_mode = SEND_STEADY;
      rcv_mode <= RCV_OPEN;
      hold_ask <= hold_ask + 1;
      for (int n = 0; n < 40; n++) begin
         if (n % 10 == 9) send_req(frame_end_req($urandom_range(0, 15), $urandom_range(0, 15)));
         else send_req(pair_req($urandom_range(0, 7), $urandom_range(0, 7)));
      end
   endtask

   // Mostly well-formed frames over a random player pool, with raw noise in between
   task automatic test_random_frames(input int n_items);
      int sent;
      int frame_len;
      int pool_base;
      int pool_size;
      int a;
      int b;
      cpg_req_type item;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 3) == 0) begin
            send_mode = send_mode_type'($urandom_range(0, 1));
            rcv_mode <= rcv_mode_type'($urandom_range(0, 2));
         end
         if ($urandom_range(0, 99) < 85) begin
            frame_len = $urandom_range(1, 18);
            pool_size = $urandom_range(2, NUM_PLAYERS);
            pool_base = $urandom_range(0, NUM_PLAYERS - pool_size);
            repeat (frame_len) begin
               a = pool_base + $urandom_range(0, pool_size - 1);
               b = ($urandom_range(0, 3) == 0) ? a
                   : pool_base + $urandom_range(0, pool_size - 1);
               send_req(pair_req(a, b));
               sent++;
            end
            send_req(frame_end_req($urandom_range(0, 15), $urandom_range(0, 15)));
            sent++;
         end else begin
            repeat ($urandom_range(1, 6)) begin
               item.req_type = 1'($urandom_range(0, 1));
               item.player_a = PLAYER_W'($urandom_range(0, 15));
               item.player_b = PLAYER_W'($urandom_range(0, 15));
               send_req(item);
               sent++;
            end
         end
      end
   endtask

   initial begin
      clear_groups();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_pair_cases();
      drain_responses();
      test_slot_exhaustion();
      drain_responses();
      test_backpressure();
      drain_responses();
      test_random_frames(590);
      drain_responses();

      $display("Ran %0d requests over %0d frames: %0d groups opened, %0d merges,",
               reqs_sent, frames_closed, groups_opened, merges_seen);
      $display("%0d refused for lack of a slot; checked %0d responses, %0d mismatches.",
               full_refusals, rsps_checked, mismatches);
      if (mismatches == 0) begin
         $display("collision_pair_grouper verification clean");
      end else begin
         $display("collision_pair_grouper verification failed");
      end
      $finish;
   end

endmodule
